// ----- src/abpg_pkg.sv -----
// shared types and constants for the alarm beep pattern generator
package abpg_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // alarm levels
  localparam logic [2:0] LVL_NONE   = 3'd0;
  localparam logic [2:0] LVL_LOW    = 3'd1;
  localparam logic [2:0] LVL_HIGH   = 3'd2;
  localparam logic [2:0] LVL_INACT  = 3'd3;
  localparam logic [2:0] LVL_URGENT = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PAUSE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PAUSE  = 8'd3;

  // configuration reset values
  localparam logic [15:0] IDLE_LIMIT_RST  = 16'd10000;
  localparam logic [15:0] BEEP_LENGTH_RST = 16'd100;
  localparam logic [15:0] LOW_PAUSE_RST   = 16'd2000;
  localparam logic [15:0] HIGH_PAUSE_RST  = 16'd500;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [2:0]  new_level;
  } in_word_t;

  typedef struct packed {
    logic buzzer_on;
    logic expired;
  } out_word_t;

  typedef struct packed {
    logic [15:0] idle_limit;
    logic [15:0] beep_length;
    logic [15:0] low_pause;
    logic [15:0] high_pause;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  level;
    logic        freshly_set;
    logic        expired_flag;
    logic [31:0] last_update_time;
    logic [31:0] last_needed_time;
    logic [31:0] last_beep_end;
    logic        beep_phase;
    logic        pin_level;
  } state_t;

endpackage

// ----- src/abpg_update.sv -----
// next-state logic: applies one word to the pattern state
module abpg_update import abpg_pkg::*; (
  input  cfg_t     cfg,
  input  state_t   cur,
  input  in_word_t word,
  output state_t   nxt
);

  logic        beeping;
  logic [31:0] interval;
  logic [31:0] pause;
  logic [31:0] since_update;
  logic [31:0] since_needed;
  logic [31:0] since_beep;
  logic [31:0] needed_ref;

  assign beeping = (cur.level == LVL_LOW) || (cur.level == LVL_HIGH) ||
                   (cur.level == LVL_INACT);
  assign interval = beeping ? {16'd0, cfg.beep_length} : 32'd0;
  assign pause = (cur.level == LVL_LOW) ? {16'd0, cfg.low_pause}
                                        : {16'd0, cfg.high_pause};
  assign since_update = word.now_ms - cur.last_update_time;
  assign since_beep   = word.now_ms - cur.last_beep_end;
  assign needed_ref   = cur.last_needed_time;
  assign since_needed = word.now_ms - needed_ref;

  always_comb begin
    nxt = cur;
    unique case (word.cmd)
      CMD_TICK: begin
        if (!cur.freshly_set && ((cur.level == LVL_NONE) || cur.expired_flag)) begin
          // idle or expired: hold the pin low, watch for expiry
          if (!cur.expired_flag && (since_needed >= {16'd0, cfg.idle_limit})) begin
            nxt.expired_flag = 1'b1;
          end
          nxt.beep_phase = 1'b0;
          nxt.pin_level  = 1'b0;
        end else begin
          if (cur.freshly_set) begin
            nxt.freshly_set      = 1'b0;
            nxt.last_needed_time = word.now_ms;
          end
          if (since_update >= interval) begin
            nxt.last_update_time = word.now_ms;
            priority if (cur.level == LVL_URGENT) begin
              nxt.beep_phase = 1'b1;
            end else if (beeping) begin
              if (!cur.beep_phase) begin
                if (since_beep >= pause) begin
                  nxt.beep_phase = 1'b1;
                end
              end else begin
                nxt.beep_phase    = 1'b0;
                nxt.last_beep_end = word.now_ms;
              end
            end else begin
              nxt.beep_phase = 1'b0;
            end
            nxt.pin_level = nxt.beep_phase;
          end
        end
      end
      CMD_SET: begin
        if (word.new_level <= LVL_URGENT) begin
          if (word.new_level != LVL_NONE) begin
            nxt.expired_flag = 1'b0;
          end
          nxt.freshly_set = 1'b1;
          nxt.level       = word.new_level;
        end
      end
      CMD_STOP: begin
        nxt.level     = LVL_NONE;
        nxt.pin_level = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/alarm_beep_pattern_generator.sv -----
// Alarm beep pattern generator: each accepted word (tick, set level or stop) yields one
// result word with the buzzer pin level and the expired flag. A word is registered on
// acceptance and applied to the state, with the result registered, once the result
// register is free or emptied. One word is taken every cycle unless the receiver stalls,
// a rate set by the single state update, three 32-bit subtract-and-compare paths.
// Configuration writes are always ready and take effect at the next word.
module alarm_beep_pattern_generator import abpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t     cfg;
  state_t   state;
  state_t   state_next;
  logic     hold_valid;
  in_word_t hold_word;
  logic     advance;

  assign cfg_ready = 1'b1;

  // the held word moves on when the result register is free or being emptied
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_limit  <= IDLE_LIMIT_RST;
      cfg.beep_length <= BEEP_LENGTH_RST;
      cfg.low_pause   <= LOW_PAUSE_RST;
      cfg.high_pause  <= HIGH_PAUSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IDLE_LIMIT:  cfg.idle_limit  <= cfg_data;
        REG_BEEP_LENGTH: cfg.beep_length <= cfg_data;
        REG_LOW_PAUSE:   cfg.low_pause   <= cfg_data;
        REG_HIGH_PAUSE:  cfg.high_pause  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  abpg_update u_update (
    .cfg  (cfg),
    .cur  (state),
    .word (hold_word),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.level            <= LVL_NONE;
      state.freshly_set      <= 1'b1;
      state.expired_flag     <= 1'b0;
      state.last_update_time <= 32'd0;
      state.last_needed_time <= 32'd0;
      state.last_beep_end    <= 32'd0;
      state.beep_phase       <= 1'b0;
      state.pin_level        <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.buzzer_on <= state_next.pin_level;
      out_word.expired   <= state_next.expired_flag;
    end
  end

`ifndef SYNTHESIS
  // the stored level is always a defined one
  assert property (@(posedge clk) disable iff (rst) state.level <= LVL_URGENT)
    else $error("level out of range");

  // expiry always drops the pin, and only a real level clears expiry
  assert property (@(posedge clk) disable iff (rst)
                   !(state.pin_level && state.expired_flag))
    else $error("buzzer driven while expired");

  // a held word that cannot move on is still held next cycle
  assert property (@(posedge clk) disable iff (rst)
                   hold_valid && !advance |=> hold_valid)
    else $error("held word lost");

  // a word only leaves the hold stage into a free or emptying result register
  assert property (@(posedge clk) disable iff (rst)
                   advance |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the alarm beep pattern generator: self-checking, with idling on both sides
`timescale 1ns / 1ps

module tb_top;
  import abpg_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  // mirrored alarm state and settings
  logic [2:0]  alarm_level    = LVL_NONE;
  logic        fresh_set      = 1'b1;
  logic        expired_seen   = 1'b0;
  logic [31:0] update_stamp   = '0;
  logic [31:0] needed_stamp   = '0;
  logic [31:0] beep_end_stamp = '0;
  logic        phase_on       = 1'b0;
  logic        pin_on         = 1'b0;
  logic [31:0] live_ms        = 32'(IDLE_LIMIT_RST);
  logic [31:0] beep_ms        = 32'(BEEP_LENGTH_RST);
  logic [31:0] low_pause_ms   = 32'(LOW_PAUSE_RST);
  logic [31:0] high_pause_ms  = 32'(HIGH_PAUSE_RST);

  out_word_t   buzzer_words_due[$];
  int          mismatches    = 0;
  int          words_sent    = 0;
  int          words_checked = 0;
  int          reg_writes    = 0;
  int          stall_left    = 0;
  logic        quiet         = 1'b0;
  logic [31:0] clock_ms      = '0;

  alarm_beep_pattern_generator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_beeping(input logic [2:0] lvl);
    return lvl == LVL_LOW || lvl == LVL_HIGH || lvl == LVL_INACT;
  endfunction

  function automatic void update_pattern(input logic [31:0] now);
    logic [31:0] interval;
    logic [31:0] since_update;
    logic [31:0] since_beep;
    logic [31:0] pause;
    interval = is_beeping(alarm_level) ? beep_ms : 32'd0;
    since_update = now - update_stamp;
    if (since_update >= interval) begin
      update_stamp = now;
      if (alarm_level == LVL_URGENT) begin
        phase_on = 1'b1;
      end else if (is_beeping(alarm_level)) begin
        if (!phase_on) begin
          pause = (alarm_level == LVL_LOW) ? low_pause_ms : high_pause_ms;
          since_beep = now - beep_end_stamp;
          if (since_beep >= pause) phase_on = 1'b1;
        end else begin
          phase_on = 1'b0;
          beep_end_stamp = now;
        end
      end else begin
        phase_on = 1'b0;
      end
      pin_on = phase_on;
    end
  endfunction

  function automatic out_word_t next_buzzer_word(input in_word_t w);
    out_word_t   r;
    logic [31:0] idle_for;
    case (w.cmd)
      CMD_TICK: begin
        if (fresh_set) begin
          fresh_set = 1'b0;
          needed_stamp = w.now_ms;
          update_pattern(w.now_ms);
        end else if (alarm_level == LVL_NONE || expired_seen) begin
          idle_for = w.now_ms - needed_stamp;
          if (!expired_seen && idle_for >= live_ms) expired_seen = 1'b1;
          phase_on = 1'b0;
          pin_on = 1'b0;
        end else begin
          update_pattern(w.now_ms);
        end
      end
      CMD_SET: begin
        if (w.new_level <= LVL_URGENT) begin
          if (w.new_level != LVL_NONE) expired_seen = 1'b0;
          fresh_set = 1'b1;
          alarm_level = w.new_level;
        end
      end
      CMD_STOP: begin
        // phase is kept on stop, only the pin drops
        alarm_level = LVL_NONE;
        pin_on = 1'b0;
      end
      default: ;
    endcase
    r.buzzer_on = pin_on;
    r.expired = expired_seen;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (buzzer_words_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with none due: buzzer %b expired %b",
                     $realtime, out_word.buzzer_on, out_word.expired);
          mismatches++;
        end else begin
          want = buzzer_words_due.pop_front();
          if (want.buzzer_on !== out_word.buzzer_on || want.expired !== out_word.expired) begin
            if (mismatches < 10)
              $display("%0t: result %0d: buzzer exp %b got %b, expired exp %b got %b",
                       $realtime, words_checked, want.buzzer_on, out_word.buzzer_on,
                       want.expired, out_word.expired);
            mismatches++;
          end
          words_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        buzzer_words_due.push_back(next_buzzer_word(in_word));
        words_sent++;
      end
    end
  end

  // receiver backpressure in bursts of random length
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] now,
                           input logic [2:0] lvl);
    in_word_t w;
    w.cmd = cmd;
    w.now_ms = now;
    w.new_level = lvl;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (buzzer_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data,
                           input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IDLE_LIMIT:  live_ms = 32'(data);
      REG_BEEP_LENGTH: beep_ms = 32'(data);
      REG_LOW_PAUSE:   low_pause_ms = 32'(data);
      REG_HIGH_PAUSE:  high_pause_ms = 32'(data);
      default: ;
    endcase
    reg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] live, input logic [15:0] beep,
                               input logic [15:0] low_p, input logic [15:0] high_p);
    wait_idle();
    cfg_write(REG_IDLE_LIMIT, live, 1'b0);
    cfg_write(REG_BEEP_LENGTH, beep, 1'b0);
    cfg_write(REG_LOW_PAUSE, low_p, 1'b0);
    cfg_write(REG_HIGH_PAUSE, high_p, 1'b1);
  endtask

  // a set followed mostly by advancing ticks, with the odd stop or re-set
  task automatic run_alarm(input logic [2:0] lvl, input int ticks, input int max_step);
    send_word(CMD_SET, $urandom, lvl);
    repeat (ticks) begin
      case ($urandom_range(0, 19))
        0: send_word(CMD_STOP, $urandom, 3'($urandom_range(0, 7)));
        1: send_word(CMD_SET, $urandom, 3'($urandom_range(0, 4)));
        default: begin
          clock_ms += $urandom_range(0, max_step);
          send_word(CMD_TICK, clock_ms, 3'($urandom_range(0, 7)));
        end
      endcase
    end
  endtask

  task automatic test_directed();
    send_word(CMD_TICK, 32'd0, 3'd7);
    send_word(CMD_TICK, 32'hFFFF_FFFF, 3'd0);     // idle none far past live time
    send_word(CMD_SET, 32'hFFFF_FFFF, 3'd5);      // levels above urgent are ignored
    send_word(CMD_SET, 32'd0, 3'd6);
    send_word(CMD_SET, 32'h5555_AAAA, 3'd7);
    send_word(2'd3, 32'hFFFF_FFFF, 3'd7);         // unknown command
    send_word(CMD_SET, 32'd0, LVL_NONE);          // none keeps expired
    send_word(CMD_SET, 32'd0, LVL_URGENT);
    send_word(CMD_TICK, 32'd1000, 3'd0);
    send_word(CMD_TICK, 32'd1000, 3'd0);
    send_word(CMD_STOP, 32'd0, 3'd0);
    send_word(CMD_TICK, 32'd1001, 3'd0);
    send_word(CMD_SET, 32'd0, LVL_LOW);           // phase was already cleared by the idle tick
    send_word(CMD_TICK, 32'd2000, 3'd0);
    send_word(CMD_TICK, 32'd2050, 3'd0);
    send_word(CMD_TICK, 32'd2100, 3'd0);
    send_word(CMD_TICK, 32'd4100, 3'd0);
    send_word(CMD_TICK, 32'd4200, 3'd0);
    send_word(CMD_SET, 32'd0, LVL_HIGH);
    send_word(CMD_TICK, 32'd4700, 3'd0);
    send_word(CMD_SET, 32'd0, LVL_INACT);
    send_word(CMD_TICK, 32'd4800, 3'd0);
    send_word(CMD_TICK, 32'd5300, 3'd0);
    send_word(CMD_SET, 32'd0, LVL_NONE);
    send_word(CMD_TICK, 32'd5400, 3'd0);
    send_word(CMD_TICK, 32'd15400, 3'd0);         // exactly live time idle
    clock_ms = 32'd15400;
  endtask

  task automatic test_level_patterns();
    int step;
    for (int s = 0; s < 3; s++) begin
      if (s == 1) load_settings(16'd300, 16'd10, 16'd60, 16'd25);
      if (s == 2)
        load_settings(16'($urandom_range(50, 2000)), 16'($urandom_range(1, 100)),
                      16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)));
      step = int'(beep_ms) + int'(low_pause_ms >> 3) + 2;
      for (int l = 1; l <= 4; l++) run_alarm(3'(l), 15, step);
    end
  endtask

  task automatic test_expiry();
    load_settings(16'd200, 16'd20, 16'd100, 16'd40);
    repeat (2) begin
      send_word(CMD_SET, $urandom, LVL_NONE);
      repeat (10) begin
        clock_ms += $urandom_range(0, 60);
        send_word(CMD_TICK, clock_ms, 3'($urandom_range(0, 7)));
      end
      send_word(CMD_SET, $urandom, LVL_NONE);
      run_alarm(LVL_LOW, 6, 30);
      send_word(CMD_STOP, $urandom, 3'($urandom_range(0, 7)));
      repeat (6) begin
        clock_ms += $urandom_range(0, 80);
        send_word(CMD_TICK, clock_ms, 3'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic test_time_wrap();
    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);
    for (int l = 1; l <= 4; l++) run_alarm(3'(l), 8, 60);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    cfg_write(8'hFF, 16'hFFFF, 1'b0);              // writes past the last register do nothing
    cfg_write(8'h04, 16'h0000, 1'b1);
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int l = 0; l <= 4; l++) run_alarm(3'(l), 5, 3);
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int l = 0; l <= 4; l++) run_alarm(3'(l), 5, 140000);
  endtask

  task automatic test_noise();
    load_settings(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 50)),
                  16'($urandom_range(0, 300)), 16'($urandom_range(0, 150)));
    repeat (60) begin
      clock_ms += $urandom_range(0, 100);
      send_word(2'($urandom_range(0, 3)), $urandom_range(0, 1) ? $urandom : clock_ms,
                3'($urandom_range(0, 7)));
    end
  endtask

  task automatic test_steady_tail();
    quiet <= 1'b1;
    repeat (4) run_alarm(3'($urandom_range(1, 4)), 12, int'(beep_ms) + 40);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_level_patterns();
    test_expiry();
    test_time_wrap();
    test_config_extremes();
    test_noise();
    test_steady_tail();
    wait_idle();
    repeat (4) @(posedge clk);
    mismatches += buzzer_words_due.size();
    $display("ran %0d words and checked %0d results over all five levels and stop",
             words_sent, words_checked);
    $display("used %0d register writes, settings from all zero to all ones", reg_writes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d results still due", buzzer_words_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- alarm_beep_pattern_generator.f -----
src/abpg_pkg.sv
src/abpg_update.sv
src/alarm_beep_pattern_generator.sv
tb/sv/tb_top.sv
